// File: hw/rtl/fcta_pkg.sv
// ----------------------------------------------------------------------------
// fcta_pkg
// Shared types and constants of the cluster allocation table unit.
// ----------------------------------------------------------------------------
package fcta_pkg;

   localparam int MAX_ENTRIES = 16384;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = ADDR_W + 1;

   localparam int KIND_W  = 2;
   localparam int COUNT_W = 15;
   localparam int INDEX_W = 14;
   localparam int WORD_W  = 32;

   localparam logic [WORD_W-1:0] LOW28_MASK = 32'h0FFF_FFFF;
   localparam logic [WORD_W-1:0] TOP4_MASK  = 32'hF000_0000;

   // first entry the free search looks at
   localparam int FIRST_FREE = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_FAT12 = 2'd0,
      KIND_FAT16 = 2'd1,
      KIND_FAT32 = 2'd2,
      KIND_UNDEF = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CSR_TABLE_KIND  = 1'b0,
      CSR_ENTRY_COUNT = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      CMD_FIND_FREE = 2'd0,
      CMD_SET_ENTRY = 2'd1,
      CMD_LOAD_RAW  = 2'd2,
      CMD_READ      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_SPACE = 2'd1,
      STAT_RANGE    = 2'd2,
      STAT_UNSUP    = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type              command;
      logic [INDEX_W-1:0]   entry_index;
      logic [WORD_W-1:0]    entry_value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]    result_value;
      status_type           status;
   } rsp_type;

   typedef enum logic [1:0] {
      WR_CLEAR = 2'd0,
      WR_RAW   = 2'd1,
      WR_FAT16 = 2'd2,
      WR_MERGE = 2'd3
   } wr_sel_type;

   typedef enum logic [2:0] {
      RSP_OK    = 3'd0,
      RSP_FOUND = 3'd1,
      RSP_EMPTY = 3'd2,
      RSP_UNSUP = 3'd3,
      RSP_RANGE = 3'd4,
      RSP_READ  = 3'd5
   } rsp_sel_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_MERGE,
      S_READ
   } state_type;

   typedef struct packed {
      logic        clr_en;
      logic        cap;
      logic        scan_init;
      logic        scan_run;
      logic        mem_wr;
      wr_sel_type  wr_sel;
      logic        rsp_en;
      rsp_sel_type rsp_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic    clr_last;
      logic    scan_found;
      logic    scan_empty;
      logic    kind_ok;
      logic    kind_fat32;
      logic    idx_ok;
      cmd_type cmd;
   } dp_stat_type;

endpackage

// File: hw/rtl/fcta_ctrl.sv
// ----------------------------------------------------------------------------
// fcta_ctrl
// Sequencer: table clear after reset, command decode, free search and
// read-modify-write steps.
// ----------------------------------------------------------------------------
module fcta_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fcta_pkg::dp_stat_type stat,
   output fcta_pkg::ctrl_cmd_type cmd
);
   import fcta_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.wr_sel    = WR_CLEAR;
      cmd.rsp_sel   = RSP_OK;
      busy          = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            busy    = 1'b0;
            cmd.cap = start;
            if (start) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in   = S_IDLE;
            cmd.rsp_en = 1'b1;
            unique case (stat.cmd)
               CMD_FIND_FREE: begin
                  if (!stat.kind_ok) begin
                     cmd.rsp_sel = RSP_UNSUP;
                  end else begin
                     cmd.rsp_en    = 1'b0;
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               CMD_SET_ENTRY: begin
                  priority if (!stat.kind_ok) begin
                     cmd.rsp_sel = RSP_UNSUP;
                  end else if (!stat.idx_ok) begin
                     cmd.rsp_sel = RSP_RANGE;
                  end else if (stat.kind_fat32) begin
                     // old word is read now, merged next cycle
                     cmd.rsp_en = 1'b0;
                     state_in   = S_MERGE;
                  end else begin
                     cmd.mem_wr = 1'b1;
                     cmd.wr_sel = WR_FAT16;
                  end
               end
               CMD_LOAD_RAW: begin
                  if (!stat.idx_ok) begin
                     cmd.rsp_sel = RSP_RANGE;
                  end else begin
                     cmd.mem_wr = 1'b1;
                     cmd.wr_sel = WR_RAW;
                  end
               end
               CMD_READ: begin
                  if (!stat.idx_ok) begin
                     cmd.rsp_sel = RSP_RANGE;
                  end else begin
                     cmd.rsp_en = 1'b0;
                     state_in   = S_READ;
                  end
               end
               default: begin
                  cmd.rsp_sel = RSP_RANGE;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            priority if (stat.scan_found) begin
               cmd.rsp_en  = 1'b1;
               cmd.rsp_sel = RSP_FOUND;
               state_in    = S_IDLE;
            end else if (stat.scan_empty) begin
               cmd.rsp_en  = 1'b1;
               cmd.rsp_sel = RSP_EMPTY;
               state_in    = S_IDLE;
            end
         end
         S_MERGE: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = WR_MERGE;
            cmd.rsp_en = 1'b1;
            state_in   = S_IDLE;
         end
         S_READ: begin
            cmd.rsp_en  = 1'b1;
            cmd.rsp_sel = RSP_READ;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/fcta_dp.sv
// ----------------------------------------------------------------------------
// fcta_dp
// Datapath: table memory, configuration registers, request capture,
// pipelined free search and result register.
// ----------------------------------------------------------------------------
module fcta_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  fcta_pkg::csr_idx_type        csr_idx,
   input  logic [fcta_pkg::COUNT_W-1:0] csr_wdata,
   input  fcta_pkg::req_type            req_data,
   input  fcta_pkg::ctrl_cmd_type       cmd,
   output fcta_pkg::dp_stat_type        stat,
   output logic                         rsp_valid,
   output fcta_pkg::rsp_type            rsp_data
);
   import fcta_pkg::*;

   logic [WORD_W-1:0]  table_ff [MAX_ENTRIES];
   logic [WORD_W-1:0]  rd_q_ff;

   kind_type           kind_ff;
   logic [COUNT_W-1:0] count_ff;
   req_type            req_ff;

   logic [ADDR_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic [CNT_W-1:0]   scan_ptr_ff, scan_ptr_in;
   logic [ADDR_W-1:0]  pend_idx_ff, pend_idx_in;
   logic               pend_vld_ff, pend_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]   live;
   logic [ADDR_W-1:0]  addr;
   logic [WORD_W-1:0]  wdata;
   logic               wen;
   logic               issue_ok;
   logic               rd_free;

   // entries in use, capped at the table depth
   always_comb begin
      if (32'(count_ff) > 32'(MAX_ENTRIES)) begin
         live = CNT_W'(MAX_ENTRIES);
      end else begin
         live = CNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_FAT32;
         count_ff <= COUNT_W'(MAX_ENTRIES);
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_TABLE_KIND:  kind_ff  <= kind_type'(csr_wdata[KIND_W-1:0]);
            CSR_ENTRY_COUNT: count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         req_ff <= req_data;
      end
   end

   assign issue_ok = (scan_ptr_ff < live);
   assign rd_free  = (kind_ff == KIND_FAT32) ? ((rd_q_ff & LOW28_MASK) == '0)
                                             : (rd_q_ff[15:0] == '0);

   always_comb begin
      clr_ptr_in  = cmd.clr_en ? clr_ptr_ff + 1'b1 : clr_ptr_ff;
      scan_ptr_in = scan_ptr_ff;
      pend_idx_in = pend_idx_ff;
      pend_vld_in = pend_vld_ff;
      if (cmd.scan_init) begin
         scan_ptr_in = CNT_W'(FIRST_FREE);
         pend_vld_in = 1'b0;
      end else if (cmd.scan_run) begin
         // read one entry per beat, checked in the cycle after
         pend_vld_in = issue_ok;
         pend_idx_in = scan_ptr_ff[ADDR_W-1:0];
         if (issue_ok) begin
            scan_ptr_in = scan_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff  <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         clr_ptr_ff  <= clr_ptr_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      pend_idx_ff <= pend_idx_in;
   end

   // single port table memory
   always_comb begin
      priority if (cmd.clr_en) begin
         addr = clr_ptr_ff;
      end else if (cmd.scan_run) begin
         addr = scan_ptr_ff[ADDR_W-1:0];
      end else begin
         addr = ADDR_W'(req_ff.entry_index);
      end
      unique case (cmd.wr_sel)
         WR_CLEAR: wdata = '0;
         WR_RAW:   wdata = req_ff.entry_value;
         WR_FAT16: wdata = {16'b0, req_ff.entry_value[15:0]};
         WR_MERGE: wdata = (rd_q_ff & TOP4_MASK) | (req_ff.entry_value & LOW28_MASK);
         default:  wdata = '0;
      endcase
      wen = cmd.clr_en | cmd.mem_wr;
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         table_ff[addr] <= wdata;
      end
      rd_q_ff <= table_ff[addr];
   end

   always_comb begin
      stat.clr_last   = (clr_ptr_ff == ADDR_W'(MAX_ENTRIES - 1));
      stat.scan_found = pend_vld_ff & rd_free;
      stat.scan_empty = ~pend_vld_ff & ~issue_ok;
      stat.kind_ok    = (kind_ff == KIND_FAT16) || (kind_ff == KIND_FAT32);
      stat.kind_fat32 = (kind_ff == KIND_FAT32);
      stat.idx_ok     = (32'(req_ff.entry_index) < 32'(live));
      stat.cmd        = req_ff.command;
   end

   always_comb begin
      rsp_valid_in = cmd.rsp_en;
      rsp_data_in  = '{result_value: '0, status: STAT_OK};
      unique case (cmd.rsp_sel)
         RSP_OK:    rsp_data_in.status = STAT_OK;
         RSP_FOUND: rsp_data_in.result_value = 32'(pend_idx_ff);
         RSP_EMPTY: rsp_data_in.status = STAT_NO_SPACE;
         RSP_UNSUP: rsp_data_in.status = STAT_UNSUP;
         RSP_RANGE: rsp_data_in.status = STAT_RANGE;
         RSP_READ:  rsp_data_in.result_value = rd_q_ff;
         default:   rsp_data_in.status = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/fat_cluster_table_allocator_unit.sv
// ----------------------------------------------------------------------------
// fat_cluster_table_allocator_unit
// Cluster allocation table with find-free, set, raw load and read commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. The table
//   holds MAX_ENTRIES 32-bit words in one single-port memory.
//   Every command returns one result beat: rsp_valid is high for exactly one
//   cycle; the receiver cannot stall, so it must take every beat.
//   Load, FAT16 set and error cases respond straight from the decode step;
//   read and FAT32 set first read the memory, then respond or merge-write.
//   Find-free reads one entry per cycle through the memory port, pipelined
//   behind a registered read; it returns the first free entry, or no space
//   when no entry below the capped entry count is free.
//   One command is in flight at a time; busy drops in the cycle the result
//   beat is shown, so the next command can follow at once.
//   After reset the unit zeroes all MAX_ENTRIES (16384) table words, one
//   word per cycle, with busy high; csr writes are taken anyway.
//   csr_we writes table_kind (index 0) or entry_count (index 1) at once;
//   write them only while the unit is idle.
// ----------------------------------------------------------------------------
module fat_cluster_table_allocator_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  fcta_pkg::csr_idx_type        csr_idx,
   input  logic [fcta_pkg::COUNT_W-1:0] csr_wdata,
   input  logic                         start,
   output logic                         busy,
   input  fcta_pkg::req_type            req_data,
   output logic                         rsp_valid,
   output fcta_pkg::rsp_type            rsp_data
);
   import fcta_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   fcta_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   fcta_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a result beat only follows a cycle in which a command was in progress
   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a command in progress");

   // an accepted command keeps the unit busy in the next cycle
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting a command");

   // failure statuses always carry a zero result
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_OK) |-> (rsp_data.result_value == '0))
      else $error("nonzero result with failure status");

   // a found free entry is never one of the two reserved entries
   a_found_index : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(cmd.rsp_sel == RSP_FOUND))
         |-> (rsp_data.result_value >= 32'(FIRST_FREE)))
      else $error("free search returned a reserved entry");

endmodule

// File: tb/fcta_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcta_table_checker
// Watches the command, result and register ports of the allocation table
// unit, keeps a shadow table and configuration, predicts the result beat of
// every accepted command and compares it field by field.
// ----------------------------------------------------------------------------
module fcta_table_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  fcta_pkg::csr_idx_type        csr_idx,
   input  logic [fcta_pkg::COUNT_W-1:0] csr_wdata,
   input  logic                         start,
   input  logic                         busy,
   input  fcta_pkg::req_type            req_data,
   input  logic                         rsp_valid,
   input  fcta_pkg::rsp_type            rsp_data,
   output int                           open_beats,
   output int                           mismatch_count
);
   import fcta_pkg::*;

   logic [WORD_W-1:0]  shadow_table [MAX_ENTRIES];
   logic [KIND_W-1:0]  shadow_kind;
   logic [COUNT_W-1:0] shadow_count;
   rsp_type            expected_q [$];
   int                 mismatches = 0;

   assign mismatch_count = mismatches;

   function automatic logic entry_free(logic [WORD_W-1:0] word);
      if (shadow_kind == KIND_FAT32) return (word & LOW28_MASK) == '0;
      return word[15:0] == '0;
   endfunction

   // runs one command against the shadow table and returns its result beat
   function automatic rsp_type apply_command(req_type beat);
      rsp_type outcome;
      int      lim;
      logic    kind_ok;
      logic    in_range;
      logic    hit;
      outcome.result_value = '0;
      outcome.status       = STAT_OK;
      lim      = (shadow_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(shadow_count);
      kind_ok  = (shadow_kind == KIND_FAT16) || (shadow_kind == KIND_FAT32);
      in_range = int'(beat.entry_index) < lim;
      case (beat.command)
         CMD_FIND_FREE: begin
            if (!kind_ok) begin
               outcome.status = STAT_UNSUP;
            end else begin
               hit = 1'b0;
               for (int k = FIRST_FREE; k < lim && !hit; k++) begin
                  if (entry_free(shadow_table[k])) begin
                     hit = 1'b1;
                     outcome.result_value = k;
                  end
               end
               if (!hit) outcome.status = STAT_NO_SPACE;
            end
         end
         CMD_SET_ENTRY: begin
            // kind check wins over the range check
            if (!kind_ok) begin
               outcome.status = STAT_UNSUP;
            end else if (!in_range) begin
               outcome.status = STAT_RANGE;
            end else if (shadow_kind == KIND_FAT32) begin
               shadow_table[beat.entry_index] =
                  (shadow_table[beat.entry_index] & TOP4_MASK) |
                  (beat.entry_value & LOW28_MASK);
            end else begin
               shadow_table[beat.entry_index] = {16'h0000, beat.entry_value[15:0]};
            end
         end
         CMD_LOAD_RAW: begin
            if (!in_range) outcome.status = STAT_RANGE;
            else shadow_table[beat.entry_index] = beat.entry_value;
         end
         default: begin
            if (!in_range) outcome.status = STAT_RANGE;
            else outcome.result_value = shadow_table[beat.entry_index];
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (shadow_table[k]) shadow_table[k] = '0;
         shadow_kind  = KIND_FAT32;
         shadow_count = COUNT_W'(MAX_ENTRIES);
         expected_q.delete();
      end else begin
         // result first: a new command may be taken on the edge that ends a result
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $error("result beat with nothing expected: result_value %h status %0d",
                      rsp_data.result_value, rsp_data.status);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value mismatch: expected %h, actual %h",
                         want.result_value, rsp_data.result_value);
                  mismatches++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_data.status);
                  mismatches++;
               end
            end
         end
         if (start && !busy) expected_q.push_back(apply_command(req_data));
         if (csr_we) begin
            if (csr_idx == CSR_TABLE_KIND) shadow_kind = csr_wdata[KIND_W-1:0];
            else shadow_count = csr_wdata;
         end
      end
      open_beats <= expected_q.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the allocation table unit through directed corner cases and random
// command streams over several table kinds and entry counts; the checker
// beside the unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
   import fcta_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 24;
   localparam int LIMIT_CYCLES = 3_000_000;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_we;
   csr_idx_type        csr_idx;
   logic [COUNT_W-1:0] csr_wdata;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_valid;
   rsp_type            rsp_data;
   int                 open_beats;
   int                 mismatch_count;
   int                 cycle_count = 0;
   logic               no_idle;

   always #6 clock = ~clock;

   fat_cluster_table_allocator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   fcta_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_idx        (csr_idx),
      .csr_wdata      (csr_wdata),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .open_beats     (open_beats),
      .mismatch_count (mismatch_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic idle_gap();
      int n;
      n = 0;
      if (!no_idle && $urandom_range(0, 2) == 0) n = $urandom_range(1, 4);
      if (n > 0) begin
         @(negedge clock) start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // start stays high after the beat is taken so back-to-back commands follow
   task automatic issue(cmd_type cmd, logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] val);
      idle_gap();
      @(negedge clock);
      start    <= 1'b1;
      req_data <= '{command: cmd, entry_index: idx, entry_value: val};
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_idle();
      @(negedge clock) start <= 1'b0;
      do @(posedge clock); while (open_beats != 0 || busy);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [COUNT_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_we <= 1'b0;
   endtask

   task automatic configure(logic [COUNT_W-1:0] kind_word, logic [COUNT_W-1:0] count);
      wait_idle();
      write_reg(CSR_TABLE_KIND, kind_word);
      write_reg(CSR_ENTRY_COUNT, count);
   endtask

   function automatic logic [WORD_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom & TOP4_MASK;
         3: return $urandom & 32'hFFFF_0000;
         4: return $urandom & 32'h0000_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // mostly allocation-style traffic: claim entries in order, release some,
   // read back, with a little noise over the whole index range
   task automatic random_phase(logic [COUNT_W-1:0] kind_word, logic [COUNT_W-1:0] count,
                               int items);
      int              lim;
      int              idx_top;
      int              ptr;
      int              pick;
      logic [WORD_W-1:0] val;
      configure(kind_word, count);
      lim     = (count > MAX_ENTRIES) ? MAX_ENTRIES : int'(count);
      idx_top = (lim + 2 > MAX_ENTRIES - 1) ? MAX_ENTRIES - 1 : lim + 2;
      ptr     = FIRST_FREE;
      repeat (items) begin
         pick = $urandom_range(0, 9);
         val  = pick_value();
         case (pick)
            0, 1: issue(CMD_FIND_FREE, INDEX_W'($urandom_range(0, idx_top)), val);
            2, 3: begin
               issue(CMD_SET_ENTRY, INDEX_W'(ptr), val | 32'h1);
               ptr = (ptr + 1 >= lim) ? FIRST_FREE : ptr + 1;
            end
            4: issue(CMD_SET_ENTRY, INDEX_W'($urandom_range(0, idx_top)), val & TOP4_MASK);
            5: issue(CMD_LOAD_RAW, INDEX_W'($urandom_range(0, idx_top)), val);
            6, 7: issue(CMD_READ, INDEX_W'($urandom_range(0, idx_top)), val);
            8: issue(CMD_SET_ENTRY, INDEX_W'($urandom_range(0, idx_top)), val);
            default: issue(cmd_type'(2'($urandom_range(0, 3))),
                           INDEX_W'($urandom_range(0, MAX_ENTRIES - 1)), $urandom);
         endcase
      end
   endtask

   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_idx   = CSR_TABLE_KIND;
      csr_wdata = '0;
      start     = 1'b0;
      req_data  = '0;
      no_idle   = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // wait out the clearing pass, reset configuration first
      wait_idle();
      issue(CMD_FIND_FREE, '0, '0);
      issue(CMD_READ, 14'h3FFF, '0);
      issue(CMD_LOAD_RAW, 14'd2, 32'hFFFF_FFFF);
      issue(CMD_LOAD_RAW, 14'd3, 32'hF000_0000);
      // top nibble alone still counts as free
      issue(CMD_FIND_FREE, '0, '0);
      issue(CMD_SET_ENTRY, 14'd3, 32'h0000_0001);
      issue(CMD_READ, 14'd3, '0);
      issue(CMD_SET_ENTRY, 14'h3FFF, 32'hFFFF_FFFF);
      issue(CMD_READ, 14'h3FFF, '0);
      issue(CMD_FIND_FREE, '0, '0);

      // count beyond capacity is clipped
      configure(COUNT_W'(KIND_FAT32), 15'd20000);
      issue(CMD_READ, 14'h3FFF, '0);

      configure(COUNT_W'(KIND_FAT32), 15'd5);
      issue(CMD_READ, 14'd5, '0);
      issue(CMD_SET_ENTRY, 14'h3FFF, 32'h1234_5678);
      issue(CMD_LOAD_RAW, 14'd4, 32'h0000_0001);
      issue(CMD_FIND_FREE, '0, '0);

      configure(COUNT_W'(KIND_FAT32), 15'd2);
      issue(CMD_FIND_FREE, '0, '0);

      configure(COUNT_W'(KIND_FAT16), 15'd0);
      issue(CMD_FIND_FREE, '0, '0);
      issue(CMD_READ, '0, '0);

      configure(COUNT_W'(KIND_FAT16), 15'd16384);
      issue(CMD_LOAD_RAW, 14'd5, 32'hFFFF_0000);
      issue(CMD_SET_ENTRY, 14'd6, 32'hABCD_1234);
      issue(CMD_READ, 14'd6, '0);
      issue(CMD_FIND_FREE, '0, '0);

      // unsupported kind beats the range check on set
      configure(COUNT_W'(KIND_FAT12), 15'd4);
      issue(CMD_FIND_FREE, '0, '0);
      issue(CMD_SET_ENTRY, 14'd10, 32'h0000_00FF);
      issue(CMD_LOAD_RAW, 14'd10, 32'h0000_00FF);
      issue(CMD_LOAD_RAW, 14'd3, 32'h0BAD_F00D);
      issue(CMD_READ, 14'd3, '0);

      // undefined kind code, every data bit set on both registers
      configure(15'h7FFF, 15'h7FFF);
      issue(CMD_SET_ENTRY, 14'd7, 32'h0000_0007);
      issue(CMD_FIND_FREE, '0, '0);

      random_phase(COUNT_W'(KIND_FAT32), 15'd24, 16);
      random_phase(COUNT_W'(KIND_FAT16), 15'd40, 16);
      random_phase(COUNT_W'(KIND_FAT32), 15'd3, 6);
      random_phase(COUNT_W'(KIND_FAT16), 15'd16384, 6);
      random_phase(COUNT_W'(KIND_FAT12), 15'd20, 6);
      random_phase(COUNT_W'(KIND_FAT32), 15'd20000, 6);
      no_idle = 1'b1;
      random_phase(COUNT_W'(KIND_FAT16), 15'd16, 16);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
